/* src/opvs_pkg.sv */
`timescale 1ns / 1ps
package opvs_pkg;

  localparam int unsigned PageW      = 20;
  localparam int unsigned InstrW     = 48;
  localparam int unsigned KindW      = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned UseDepthDef  = 64;
  localparam int unsigned PageDepthDef = 32;

  localparam logic [KindW-1:0] KindRecord  = 2'd0;
  localparam logic [KindW-1:0] KindPromote = 2'd1;
  localparam logic [KindW-1:0] KindClear   = 2'd2;

  localparam logic [StatusW-1:0] StOk        = 2'd0;
  localparam logic [StatusW-1:0] StUseFull   = 2'd1;
  localparam logic [StatusW-1:0] StPageFull  = 2'd2;
  localparam logic [StatusW-1:0] StUseEmpty  = 2'd3;

  // which table a scan walks and what it looks for
  localparam logic [1:0] PhUse    = 2'd0;
  localparam logic [1:0] PhPage   = 2'd1;
  localparam logic [1:0] PhVictim = 2'd2;

  typedef struct packed {
    logic       capture;
    logic       clear_tbl;
    logic       start;
    logic       scan;
    logic [1:0] phase;
    logic       update;
    logic       finish;
  } ctl_cmd_t;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic             scan_done;
    logic             umin_found;
    logic             out_busy;
  } ctl_sts_t;

endpackage

/* src/opvs_if.sv */
`timescale 1ns / 1ps
interface opvs_in_if
  import opvs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic [PageW-1:0]  page;
  logic [InstrW-1:0] instr_index;

  modport source (output valid, kind, page, instr_index, input ready);
  modport sink   (input valid, kind, page, instr_index, output ready);
endinterface

interface opvs_out_if
  import opvs_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [PageW-1:0]   victim_page;
  logic [StatusW-1:0] status;

  modport source (output valid, victim_page, status, input ready);
  modport sink   (input valid, victim_page, status, output ready);
endinterface

/* src/opvs_ram.sv */
`timescale 1ns / 1ps
module opvs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* src/opvs_ctrl.sv */
`timescale 1ns / 1ps
module opvs_ctrl
  import opvs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     out_ready_i,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDisp  = 3'd1;
  localparam logic [2:0] SUScan = 3'd2;
  localparam logic [2:0] SPScan = 3'd3;
  localparam logic [2:0] SUpd   = 3'd4;
  localparam logic [2:0] SVScan = 3'd5;
  localparam logic [2:0] SFin   = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == SIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cmd_o.start   = 1'b1;
          state_d       = SDisp;
        end
      end
      SDisp: begin
        if (sts_i.kind == KindRecord || sts_i.kind == KindPromote) begin
          state_d = SUScan;
        end else begin
          cmd_o.clear_tbl = (sts_i.kind == KindClear);
          state_d         = SVScan;
        end
      end
      SUScan: begin
        cmd_o.scan  = 1'b1;
        cmd_o.phase = PhUse;
        if (sts_i.scan_done) begin
          cmd_o.start = 1'b1;
          if (sts_i.kind == KindRecord) begin
            state_d = SUpd;
          end else if (sts_i.umin_found) begin
            state_d = SPScan;
          end else begin
            state_d = SVScan;
          end
        end
      end
      SPScan: begin
        cmd_o.scan  = 1'b1;
        cmd_o.phase = PhPage;
        if (sts_i.scan_done) begin
          state_d = SUpd;
        end
      end
      SUpd: begin
        cmd_o.update = 1'b1;
        cmd_o.start  = 1'b1;
        state_d      = SVScan;
      end
      SVScan: begin
        cmd_o.scan  = 1'b1;
        cmd_o.phase = PhVictim;
        if (sts_i.scan_done) begin
          state_d = SFin;
        end
      end
      SFin: begin
        if (!sts_i.out_busy || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/opvs_dpath.sv */
`timescale 1ns / 1ps
module opvs_dpath
  import opvs_pkg::*;
#(
  parameter int unsigned UseDepth  = UseDepthDef,
  parameter int unsigned PageDepth = PageDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctl_cmd_t           cmd_i,
  output ctl_sts_t           sts_o,
  input  logic [KindW-1:0]   kind_i,
  input  logic [PageW-1:0]   page_i,
  input  logic [InstrW-1:0]  instr_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [PageW-1:0]   victim_o,
  output logic [StatusW-1:0] status_o
);

  localparam int unsigned UAw  = $clog2(UseDepth);
  localparam int unsigned PAw  = $clog2(PageDepth);
  localparam int unsigned MaxD = (UseDepth > PageDepth) ? UseDepth : PageDepth;
  localparam int unsigned Cw   = $clog2(MaxD + 1);
  localparam int unsigned EntW = InstrW + PageW;

  logic [KindW-1:0]  kind_q;
  logic [PageW-1:0]  page_q;
  logic [InstrW-1:0] instr_q;

  logic [Cw-1:0] cnt_q, rd_idx_q, depth, last;
  logic          rd_act_q, issue, done;

  logic [UseDepth-1:0]  use_vld_q;
  logic [PageDepth-1:0] page_vld_q;

  logic              dup_q, ufree_q, umin_q;
  logic [UAw-1:0]    ufree_idx_q;
  logic [InstrW-1:0] umin_key_q;
  logic [PageW-1:0]  umin_page_q;
  logic              pmatch_q, pfree_q;
  logic [PAw-1:0]    pmatch_idx_q, pfree_idx_q;
  logic [InstrW-1:0] pmatch_val_q;
  logic [InstrW-1:0] best_val_q;
  logic [PageW-1:0]  best_page_q;

  logic               out_valid_q;
  logic [PageW-1:0]   victim_q;
  logic [StatusW-1:0] status_q, status_d;

  logic [EntW-1:0]   urd, prd;
  logic [InstrW-1:0] u_key, p_val, new_val;
  logic [PageW-1:0]  u_page, p_key;
  logic              u_vld, p_vld;
  logic              use_we, page_we;
  logic [PAw-1:0]    page_waddr;

  assign depth = (cmd_i.phase == PhUse) ? Cw'(UseDepth) : Cw'(PageDepth);
  assign last  = depth - Cw'(1);
  assign issue = cmd_i.scan && (cnt_q < depth);
  assign done  = rd_act_q && (rd_idx_q == last);

  assign u_key  = urd[EntW-1:PageW];
  assign u_page = urd[PageW-1:0];
  assign p_key  = prd[EntW-1:InstrW];
  assign p_val  = prd[InstrW-1:0];
  assign u_vld  = use_vld_q[rd_idx_q[UAw-1:0]];
  assign p_vld  = page_vld_q[rd_idx_q[PAw-1:0]];

  assign use_we     = cmd_i.update && (kind_q == KindRecord) && !dup_q && ufree_q;
  assign page_we    = cmd_i.update && (kind_q == KindPromote) && umin_q &&
                      (pmatch_q || pfree_q);
  assign page_waddr = pmatch_q ? pmatch_idx_q : pfree_idx_q;
  assign new_val    = (pmatch_q && pmatch_val_q < umin_key_q) ? pmatch_val_q : umin_key_q;

  opvs_ram #(.Width(EntW), .Depth(UseDepth)) u_use_ram (
    .clk_i,
    .we_i    (use_we),
    .waddr_i (ufree_idx_q),
    .wdata_i ({instr_q, page_q}),
    .raddr_i (cnt_q[UAw-1:0]),
    .rdata_o (urd)
  );

  opvs_ram #(.Width(EntW), .Depth(PageDepth)) u_page_ram (
    .clk_i,
    .we_i    (page_we),
    .waddr_i (page_waddr),
    .wdata_i ({umin_page_q, new_val}),
    .raddr_i (cnt_q[PAw-1:0]),
    .rdata_o (prd)
  );

  always_comb begin
    status_d = StOk;
    if (kind_q == KindRecord) begin
      status_d = (!dup_q && !ufree_q) ? StUseFull : StOk;
    end else if (kind_q == KindPromote) begin
      if (!umin_q) begin
        status_d = StUseEmpty;
      end else if (!pmatch_q && !pfree_q) begin
        status_d = StPageFull;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_i;
      page_q  <= page_i;
      instr_q <= instr_i;
    end
    if (cmd_i.finish) begin
      victim_q <= best_page_q;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q        <= '0;
      rd_idx_q     <= '0;
      rd_act_q     <= 1'b0;
      use_vld_q    <= '0;
      page_vld_q   <= '0;
      dup_q        <= 1'b0;
      ufree_q      <= 1'b0;
      umin_q       <= 1'b0;
      ufree_idx_q  <= '0;
      umin_key_q   <= '0;
      umin_page_q  <= '0;
      pmatch_q     <= 1'b0;
      pfree_q      <= 1'b0;
      pmatch_idx_q <= '0;
      pfree_idx_q  <= '0;
      pmatch_val_q <= '0;
      best_val_q   <= '0;
      best_page_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        cnt_q    <= '0;
        rd_act_q <= 1'b0;
      end else begin
        rd_act_q <= issue;
        rd_idx_q <= cnt_q;
        if (issue) begin
          cnt_q <= cnt_q + Cw'(1);
        end
      end
      if (cmd_i.capture) begin
        dup_q       <= 1'b0;
        ufree_q     <= 1'b0;
        umin_q      <= 1'b0;
        pmatch_q    <= 1'b0;
        pfree_q     <= 1'b0;
        best_val_q  <= '0;
        best_page_q <= '0;
      end
      if (cmd_i.clear_tbl) begin
        use_vld_q  <= '0;
        page_vld_q <= '0;
      end
      if (rd_act_q && cmd_i.scan) begin
        case (cmd_i.phase)
          PhUse: begin
            if (u_vld) begin
              if (u_key == instr_q) begin
                dup_q <= 1'b1;
              end
              if (!umin_q || u_key < umin_key_q) begin
                umin_q      <= 1'b1;
                umin_key_q  <= u_key;
                umin_page_q <= u_page;
              end
            end else if (!ufree_q) begin
              ufree_q     <= 1'b1;
              ufree_idx_q <= rd_idx_q[UAw-1:0];
            end
          end
          PhPage: begin
            if (p_vld) begin
              if (!pmatch_q && p_key == umin_page_q) begin
                pmatch_q     <= 1'b1;
                pmatch_idx_q <= rd_idx_q[PAw-1:0];
                pmatch_val_q <= p_val;
              end
            end else if (!pfree_q) begin
              pfree_q     <= 1'b1;
              pfree_idx_q <= rd_idx_q[PAw-1:0];
            end
          end
          PhVictim: begin
            if (p_vld && p_val != '0 && (p_val > best_val_q ||
                (p_val == best_val_q && p_key < best_page_q))) begin
              best_val_q  <= p_val;
              best_page_q <= p_key;
            end
          end
          default: ;
        endcase
      end
      if (use_we) begin
        use_vld_q[ufree_idx_q] <= 1'b1;
      end
      if (page_we) begin
        page_vld_q[page_waddr] <= 1'b1;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.scan_done  = done;
  assign sts_o.umin_found = umin_q;
  assign sts_o.out_busy   = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign victim_o    = victim_q;
  assign status_o    = status_q;

endmodule

/* src/optimal_page_victim_select.sv */
// Sequence: the use-table walk (record, promote), the page-table walk (promote with a
//   non-empty use table), then the victim walk over the page table for every kind;
//   an unread previous result stalls the finish until it is taken.
// Throughput: one item at a time, the next accepted from the cycle the result goes valid;
//   set by the serial walks over the use and page tables, one entry a cycle per RAM.
// Reset: asynchronous active low; empties both tables at once, no sweep.
`timescale 1ns / 1ps
module optimal_page_victim_select
  import opvs_pkg::*;
#(
  parameter int unsigned USE_DEPTH  = UseDepthDef,
  parameter int unsigned PAGE_DEPTH = PageDepthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  opvs_in_if.sink   in_i,
  opvs_out_if.source out_o
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  opvs_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  opvs_dpath #(.UseDepth(USE_DEPTH), .PageDepth(PAGE_DEPTH)) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (in_i.kind),
    .page_i      (in_i.page),
    .instr_i     (in_i.instr_index),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .victim_o    (out_o.victim_page),
    .status_o    (out_o.status)
  );

endmodule

/* src/opvs_chk.sv */
`timescale 1ns / 1ps
module opvs_chk
  import opvs_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [PageW-1:0]   victim_i,
  input logic [StatusW-1:0] status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(victim_i) && $stable(status_i))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after accept");

  a_busy_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> ##2 !in_ready_i)
    else $error("item finished too early");

  a_no_result_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> !out_valid_i)
    else $error("result without work");

endmodule

bind optimal_page_victim_select opvs_chk u_opvs_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .victim_i    (out_o.victim_page),
  .status_i    (out_o.status)
);

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import opvs_pkg::*;

  localparam int unsigned UseN  = UseDepthDef;
  localparam int unsigned PageN = PageDepthDef;
  localparam logic [KindW-1:0] KindUnused = 2'd3;

  class victim_board;
    logic [InstrW-1:0] use_key [UseN];
    logic [PageW-1:0]  use_pg  [UseN];
    bit                use_vld [UseN];
    logic [PageW-1:0]  pg_key  [PageN];
    logic [InstrW-1:0] pg_next [PageN];
    bit                pg_vld  [PageN];
    logic [PageW+StatusW-1:0] pending [$];
    int errors;

    function void wipe();
      foreach (use_vld[i]) use_vld[i] = 0;
      foreach (pg_vld[i]) pg_vld[i] = 0;
    endfunction

    function void note_item(logic [KindW-1:0] kind, logic [PageW-1:0] pg,
                            logic [InstrW-1:0] instr);
      logic [StatusW-1:0] st;
      int slot, best;
      logic [InstrW-1:0] bval;
      logic [PageW-1:0] bpage;
      bit hit;
      st = StOk;
      slot = -1;
      best = -1;
      hit = 0;
      if (kind == KindRecord) begin
        foreach (use_vld[i]) begin
          if (use_vld[i]) begin
            if (use_key[i] == instr) hit = 1;
          end else if (slot < 0) begin
            slot = i;
          end
        end
        if (!hit) begin
          if (slot < 0) st = StUseFull;
          else begin
            use_key[slot] = instr;
            use_pg[slot] = pg;
            use_vld[slot] = 1;
          end
        end
      end else if (kind == KindPromote) begin
        foreach (use_vld[i])
          if (use_vld[i] && (best < 0 || use_key[i] < use_key[best])) best = i;
        if (best < 0) st = StUseEmpty;
        else begin
          foreach (pg_vld[i]) begin
            if (!hit) begin
              if (pg_vld[i]) begin
                if (pg_key[i] == use_pg[best]) begin
                  if (pg_next[i] > use_key[best]) pg_next[i] = use_key[best];
                  hit = 1;
                end
              end else if (slot < 0) begin
                slot = i;
              end
            end
          end
          if (!hit) begin
            if (slot < 0) st = StPageFull;
            else begin
              pg_key[slot] = use_pg[best];
              pg_next[slot] = use_key[best];
              pg_vld[slot] = 1;
            end
          end
        end
      end else if (kind == KindClear) begin
        wipe();
      end
      bval = '0;
      bpage = '0;
      foreach (pg_vld[i])
        if (pg_vld[i] && pg_next[i] != 0 &&
            (pg_next[i] > bval || (pg_next[i] == bval && pg_key[i] < bpage))) begin
          bval = pg_next[i];
          bpage = pg_key[i];
        end
      pending.push_back({bpage, st});
    endfunction

    function void check_result(logic [PageW-1:0] pg, logic [StatusW-1:0] st);
      logic [PageW+StatusW-1:0] exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result victim %h status %0d", $time, pg, st);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (exp_r[StatusW+:PageW] !== pg) begin
        $display("%0t: victim expected %h actual %h", $time, exp_r[StatusW+:PageW], pg);
        errors++;
      end
      if (exp_r[StatusW-1:0] !== st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r[StatusW-1:0], st);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  bit   calm = 0;
  victim_board board;

  opvs_in_if  in_if ();
  opvs_out_if out_if ();

  optimal_page_victim_select u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    in_if.valid = 0;
    in_if.kind = KindRecord;
    in_if.page = '0;
    in_if.instr_index = '0;
    out_if.ready = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        board.note_item(in_if.kind, in_if.page, in_if.instr_index);
      if (out_if.valid && out_if.ready)
        board.check_result(out_if.victim_page, out_if.status);
    end
  end

  initial begin : sink_side
    int n;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 0;
        n = $urandom_range(1, 14);
        repeat (n) @(posedge clk_i);
      end
      out_if.ready <= 1;
      n = $urandom_range(1, 20);
      repeat (n) @(posedge clk_i);
    end
  end

  task automatic send(logic [KindW-1:0] kind, logic [PageW-1:0] pg,
                      logic [InstrW-1:0] instr);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 0;
      n = $urandom_range(1, 14);
      repeat (n) @(posedge clk_i);
    end
    in_if.valid <= 1;
    in_if.kind <= kind;
    in_if.page <= pg;
    in_if.instr_index <= instr;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  function automatic logic [InstrW-1:0] rand_instr();
    case ($urandom_range(0, 3))
      0: return InstrW'($urandom_range(0, 40));
      1: return InstrW'({$urandom, $urandom});
      2: return {InstrW{1'b1}} - InstrW'($urandom_range(0, 3));
      default: return InstrW'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic logic [PageW-1:0] rand_page();
    if ($urandom_range(0, 2) == 0) return PageW'($urandom);
    return PageW'($urandom_range(0, 40));
  endfunction

  initial begin : stim
    int k;
    logic [KindW-1:0] kd;
    board = new();
    board.wipe();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send(KindPromote, '0, '0);
    send(KindRecord, '1, '1);
    send(KindRecord, 20'h00001, 48'd0);
    send(KindRecord, 20'h12345, 48'd0);
    send(KindPromote, '0, '0);
    send(KindPromote, '0, '0);
    send(KindRecord, '0, 48'd5);
    send(KindPromote, '0, '0);
    send(KindRecord, 20'h00007, 48'd3);
    send(KindPromote, '0, '0);
    send(KindUnused, '1, '1);
    send(KindClear, '1, '1);
    for (int i = 0; i < UseN + 2; i++)
      send(KindRecord, PageW'(i + 1), InstrW'(i + 1));
    for (int i = 0; i < PageN + 3; i++) begin
      send(KindPromote, '0, '0);
      send(KindRecord, PageW'(i + 100), InstrW'(i));
    end
    send(KindRecord, '1, '1);
    send(KindPromote, '0, '0);
    send(KindClear, '0, '0);
    for (int i = 0; i < 750; i++) begin
      if (i == 620) calm = 1;
      k = $urandom_range(0, 99);
      if (k < 55) kd = KindRecord;
      else if (k < 92) kd = KindPromote;
      else if (k < 96) kd = KindClear;
      else kd = KindUnused;
      send(kd, rand_page(), rand_instr());
    end
    in_if.valid <= 0;
    k = 0;
    while (board.pending.size() != 0 && k < 100000) begin
      @(posedge clk_i);
      k++;
    end
    repeat (200) @(posedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin : watchdog
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
